### rtl/cht_pkg.sv
// ----------------------------------------------------------------------------
// cht_pkg: shared types and codes for the cuckoo hash table
// Operation and status codes, payload structs and the back-end state type.
// ----------------------------------------------------------------------------
package cht_pkg;

    localparam logic [1:0] OP_INSERT   = 2'd0;
    localparam logic [1:0] OP_LOOKUP   = 2'd1;
    localparam logic [1:0] OP_REMOVE   = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FOUND     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_REMOVED   = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    localparam logic [7:0] KICK_RESET = 8'd100;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key;
        logic [31:0] value;
    } t_cht_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
        logic [31:0] evicted_key;
        logic [31:0] evicted_value;
        logic [5:0]  entry_count;
    } t_cht_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_KICK_A,
        S_KICK_B,
        S_DONE
    } t_cht_state;

endpackage

### rtl/cuckoo_hash_table.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_table: two-table cuckoo hash store with kick-limited inserts
// Queue in front, table sequencer behind, one result per item.
// ----------------------------------------------------------------------------
// channel   direction  handshake     payload
// input     in         valid/stall   t_cht_in  (operation, key, value)
// result    out        valid/stall   t_cht_out (status, values, count)
// config    in         valid/ready   kick_limit, 8 bits
//
// Lookup, remove, update: read slots, check, done, idle.
// Insert by kicking: up to kick_limit A/B rounds, one slot per cycle.
// Reset clears valid bits, count and queue; key/value stores stay as they are.
// A stalled result holds the sequencer; the queue takes two more items.
module cuckoo_hash_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  cht_pkg::t_cht_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output cht_pkg::t_cht_out o_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data
);
    import cht_pkg::*;

    logic [7:0] r_kick;
    logic       w_q_valid, w_q_stall;
    t_cht_in    w_q_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kick <= KICK_RESET;
        end else if (i_cfg_valid) begin
            r_kick <= i_cfg_data;
        end
    end

    cht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (w_q_valid),
        .i_stall (w_q_stall),
        .o_data  (w_q_data)
    );

    cht_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_kick_limit (r_kick),
        .i_valid      (w_q_valid),
        .o_stall      (w_q_stall),
        .i_data       (w_q_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

endmodule

### rtl/cht_queue.sv
// ----------------------------------------------------------------------------
// cht_queue: two-entry queue between front and back end
// Registers the accepted item; valid/stall on both sides.
// ----------------------------------------------------------------------------
module cht_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  cht_pkg::t_cht_in i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output cht_pkg::t_cht_in o_data
);
    import cht_pkg::*;

    t_cht_in    r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !w_pop) else $error("pop from empty queue");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count lost a push");

endmodule

### rtl/cht_engine.sv
// ----------------------------------------------------------------------------
// cht_engine: table stores and operation sequencer
// Reads both slots, then updates, removes, looks up or runs kick rounds.
// ----------------------------------------------------------------------------
module cht_engine #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_kick_limit,
    input  logic              i_valid,
    output logic              o_stall,
    input  cht_pkg::t_cht_in  i_data,
    output logic              o_valid,
    input  logic              i_stall,
    output cht_pkg::t_cht_out o_data
);
    import cht_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(2 * TABLE_DEPTH + 1);

    logic [31:0] r_ka [TABLE_DEPTH];
    logic [31:0] r_va [TABLE_DEPTH];
    logic [31:0] r_kb [TABLE_DEPTH];
    logic [31:0] r_vb [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vla, r_vlb;

    t_cht_state r_state, n_state;
    t_cht_in    r_item;
    logic [31:0] r_ck, r_cv;
    logic [7:0]  r_round;
    logic [CW-1:0] r_count;
    logic [AW-1:0] r_sa, r_sb;
    logic [31:0] r_rka, r_rva, r_rkb, r_rvb;
    logic        r_rla, r_rlb;
    t_cht_out    r_res, n_res;
    t_cht_out    r_out;
    logic        r_ovalid;

    logic [AW-1:0] w_sa_ck, w_sb_ck;
    logic          w_hit_a, w_hit_b, w_take;
    logic [31:0]   w_lo_in;

    // first slot from key, second from key*31+17, low address bits only
    function automatic logic [AW-1:0] slot_b(input logic [31:0] k);
        logic [37:0] p;
        p = {k, 5'd0} - {5'd0, k} + 38'd17;
        return p[AW-1:0];
    endfunction

    assign w_lo_in = r_ck;
    assign w_sa_ck = w_lo_in[AW-1:0];
    assign w_sb_ck = slot_b(r_ck);
    assign w_hit_a = r_rla && (r_rka == r_item.key);
    assign w_hit_b = r_rlb && (r_rkb == r_item.key);
    assign w_take  = i_valid && (r_state == S_IDLE);
    assign o_stall = !(r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_READ;
            S_READ:   n_state = S_CHECK;
            S_CHECK: begin
                if (r_item.operation == OP_INSERT && !w_hit_a && !w_hit_b &&
                    i_kick_limit != 8'd0) begin
                    n_state = S_KICK_A;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_KICK_A: n_state = r_vla[w_sa_ck] ? S_KICK_B : S_DONE;
            S_KICK_B: begin
                if (!r_vlb[w_sb_ck] || r_round + 8'd1 >= i_kick_limit) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_KICK_A;
                end
            end
            S_DONE:   if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // working result, built while the previous one may still be held
    always_comb begin
        n_res = r_res;
        unique case (r_state)
            S_CHECK: begin
                n_res = '0;
                n_res.entry_count = 6'(r_count);
                case (r_item.operation)
                    OP_INSERT: begin
                        if (w_hit_a || w_hit_b) begin
                            n_res.status = ST_UPDATED;
                        end else begin
                            n_res.status        = ST_FULL;
                            n_res.evicted_key   = r_item.key;
                            n_res.evicted_value = r_item.value;
                        end
                    end
                    OP_REMOVE: begin
                        if (w_hit_a || w_hit_b) begin
                            n_res.entry_count = 6'(r_count - CW'(1));
                            n_res.status      = ST_REMOVED;
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        if (w_hit_a) begin
                            n_res.status     = ST_FOUND;
                            n_res.read_value = r_rva;
                        end else if (w_hit_b) begin
                            n_res.status     = ST_FOUND;
                            n_res.read_value = r_rvb;
                        end else begin
                            n_res.status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_KICK_A: begin
                if (!r_vla[w_sa_ck]) begin
                    n_res.entry_count   = 6'(r_count + CW'(1));
                    n_res.status        = ST_INSERTED;
                    n_res.evicted_key   = '0;
                    n_res.evicted_value = '0;
                end else begin
                    n_res.evicted_key   = r_ka[w_sa_ck];
                    n_res.evicted_value = r_va[w_sa_ck];
                end
            end
            S_KICK_B: begin
                if (!r_vlb[w_sb_ck]) begin
                    n_res.entry_count   = 6'(r_count + CW'(1));
                    n_res.status        = ST_INSERTED;
                    n_res.evicted_key   = '0;
                    n_res.evicted_value = '0;
                end else begin
                    n_res.evicted_key   = r_kb[w_sb_ck];
                    n_res.evicted_value = r_vb[w_sb_ck];
                end
            end
            default: ;
        endcase
    end

    // stores: only the sequencer writes them
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rka <= r_ka[r_sa];
            r_rva <= r_va[r_sa];
            r_rkb <= r_kb[r_sb];
            r_rvb <= r_vb[r_sb];
        end
        if (r_state == S_CHECK && r_item.operation == OP_INSERT) begin
            if (w_hit_a)      r_va[r_sa] <= r_item.value;
            else if (w_hit_b) r_vb[r_sb] <= r_item.value;
        end
        if (r_state == S_KICK_A) begin
            r_ka[w_sa_ck] <= r_ck;
            r_va[w_sa_ck] <= r_cv;
            r_ck <= r_ka[w_sa_ck];
            r_cv <= r_va[w_sa_ck];
        end else if (r_state == S_KICK_B) begin
            r_kb[w_sb_ck] <= r_ck;
            r_vb[w_sb_ck] <= r_cv;
            r_ck <= r_kb[w_sb_ck];
            r_cv <= r_vb[w_sb_ck];
        end else if (w_take) begin
            r_ck <= i_data.key;
            r_cv <= i_data.value;
        end
        if (w_take) begin
            r_item <= i_data;
            r_sa   <= i_data.key[AW-1:0];
            r_sb   <= slot_b(i_data.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vla    <= '0;
            r_vlb    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_round  <= 8'd0;
            r_rla    <= 1'b0;
            r_rlb    <= 1'b0;
            r_res    <= '0;
            r_out    <= '0;
        end else begin
            r_state  <= n_state;
            r_res    <= n_res;
            r_ovalid <= (r_ovalid && i_stall) ||
                        (r_state == S_DONE && (!r_ovalid || !i_stall));
            if (r_state == S_DONE && (!r_ovalid || !i_stall)) r_out <= r_res;
            if (r_state == S_READ) begin
                r_rla <= r_vla[r_sa];
                r_rlb <= r_vlb[r_sb];
                r_round <= 8'd0;
            end
            if (r_state == S_CHECK && r_item.operation == OP_REMOVE &&
                (w_hit_a || w_hit_b)) begin
                if (w_hit_a) r_vla[r_sa] <= 1'b0;
                else         r_vlb[r_sb] <= 1'b0;
                r_count <= r_count - CW'(1);
            end
            if (r_state == S_KICK_A && !r_vla[w_sa_ck]) begin
                r_vla[w_sa_ck] <= 1'b1;
                r_count <= r_count + CW'(1);
            end
            if (r_state == S_KICK_B) begin
                if (!r_vlb[w_sb_ck]) begin
                    r_vlb[w_sb_ck] <= 1'b1;
                    r_count <= r_count + CW'(1);
                end else begin
                    r_round <= r_round + 8'd1;
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(2 * TABLE_DEPTH)) else $error("occupancy overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KICK_B) |=> (r_state == S_KICK_A || r_state == S_DONE))
        else $error("bad kick sequence");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_stall) |=> $stable(r_out)) else $error("result changed");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KICK_A || r_state == S_KICK_B) |-> (r_round < i_kick_limit))
        else $error("round overrun");

endmodule

### sim/cuckoo_hash_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cuckoo_hash_table_tb: self-checking bench for the cuckoo hash table
// Drives inserts, lookups, removes and reserved codes over a small key pool
// so that the tables fill, kick and overflow. Every transfer is predicted by
// a local table model and each result is compared field by field, in order.
// ----------------------------------------------------------------------------
module cuckoo_hash_table_tb;
    import cht_pkg::*;

    localparam int DEPTH     = 16;
    localparam int POOL_SIZE = 40;
    localparam int LIMIT     = 3000000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    t_cht_in    i_data = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    t_cht_out   o_data;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data = '0;

    // local copy of the table
    logic [31:0] tab_a_key [DEPTH];
    logic [31:0] tab_a_val [DEPTH];
    logic        tab_a_vld [DEPTH];
    logic [31:0] tab_b_key [DEPTH];
    logic [31:0] tab_b_val [DEPTH];
    logic        tab_b_vld [DEPTH];
    logic [5:0]  occupancy;
    logic [7:0]  kick_limit;

    t_cht_out    pending_results[$];
    logic [31:0] key_pool [POOL_SIZE];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;
    int          errors;
    int          cycles;

    cuckoo_hash_table #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int first_slot(logic [31:0] k);
        return int'(k % DEPTH);
    endfunction

    function automatic int second_slot(logic [31:0] k);
        logic [63:0] wide;
        wide = 64'(k) * 64'd31 + 64'd17;
        return int'(wide % DEPTH);
    endfunction

    function automatic t_cht_out table_outcome(t_cht_in it);
        t_cht_out    res;
        int          ia;
        int          ib;
        int          s;
        int          round;
        bit          hit_a;
        bit          hit_b;
        bit          placed;
        logic [31:0] carry_k;
        logic [31:0] carry_v;
        logic [31:0] tmp;
        res = '0;
        res.status = ST_NOT_FOUND;
        ia = first_slot(it.key);
        ib = second_slot(it.key);
        hit_a = tab_a_vld[ia] && tab_a_key[ia] == it.key;
        hit_b = tab_b_vld[ib] && tab_b_key[ib] == it.key;
        if (it.operation == OP_INSERT) begin
            if (hit_a) begin
                tab_a_val[ia] = it.value;
                res.status = ST_UPDATED;
            end else if (hit_b) begin
                tab_b_val[ib] = it.value;
                res.status = ST_UPDATED;
            end else begin
                carry_k = it.key;
                carry_v = it.value;
                placed = 1'b0;
                for (round = 0; round < kick_limit && !placed; round++) begin
                    s = first_slot(carry_k);
                    if (!tab_a_vld[s]) begin
                        tab_a_vld[s] = 1'b1;
                        tab_a_key[s] = carry_k;
                        tab_a_val[s] = carry_v;
                        placed = 1'b1;
                    end else begin
                        tmp = tab_a_key[s]; tab_a_key[s] = carry_k; carry_k = tmp;
                        tmp = tab_a_val[s]; tab_a_val[s] = carry_v; carry_v = tmp;
                        s = second_slot(carry_k);
                        if (!tab_b_vld[s]) begin
                            tab_b_vld[s] = 1'b1;
                            tab_b_key[s] = carry_k;
                            tab_b_val[s] = carry_v;
                            placed = 1'b1;
                        end else begin
                            tmp = tab_b_key[s]; tab_b_key[s] = carry_k; carry_k = tmp;
                            tmp = tab_b_val[s]; tab_b_val[s] = carry_v; carry_v = tmp;
                        end
                    end
                end
                if (placed) begin
                    occupancy = occupancy + 6'd1;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_FULL;
                    res.evicted_key = carry_k;
                    res.evicted_value = carry_v;
                end
            end
        end else if (it.operation == OP_REMOVE) begin
            if (hit_a) begin
                tab_a_vld[ia] = 1'b0;
                occupancy = occupancy - 6'd1;
                res.status = ST_REMOVED;
            end else if (hit_b) begin
                tab_b_vld[ib] = 1'b0;
                occupancy = occupancy - 6'd1;
                res.status = ST_REMOVED;
            end
        end else begin
            // the unused code reads like a lookup
            if (hit_a) begin
                res.read_value = tab_a_val[ia];
                res.status = ST_FOUND;
            end else if (hit_b) begin
                res.read_value = tab_b_val[ib];
                res.status = ST_FOUND;
            end
        end
        res.entry_count = occupancy;
        return res;
    endfunction

    // receiver stall, with an optional counted hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_stall = 1'b1;
            hold_cycles--;
        end else begin
            i_stall = ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cht_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, o_data);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_data.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, o_data.status);
                    errors++;
                end
                if (o_data.read_value !== want.read_value) begin
                    $display("%0t: read_value exp %h got %h", $time, want.read_value,
                             o_data.read_value);
                    errors++;
                end
                if (o_data.evicted_key !== want.evicted_key) begin
                    $display("%0t: evicted_key exp %h got %h", $time, want.evicted_key,
                             o_data.evicted_key);
                    errors++;
                end
                if (o_data.evicted_value !== want.evicted_value) begin
                    $display("%0t: evicted_value exp %h got %h", $time, want.evicted_value,
                             o_data.evicted_value);
                    errors++;
                end
                if (o_data.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count exp %0d got %0d", $time, want.entry_count,
                             o_data.entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic send_item(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        t_cht_in it;
        it.operation = op;
        it.key = k;
        it.value = v;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_data = it;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        pending_results = {pending_results, table_outcome(it)};
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_kick_limit(logic [7:0] v);
        wait_drained();
        repeat (8) @(negedge i_clk);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        kick_limit = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random_item();
        int          pick;
        logic [1:0]  op;
        logic [31:0] k;
        pick = $urandom_range(99);
        if (pick < 50) op = OP_INSERT;
        else if (pick < 75) op = OP_LOOKUP;
        else if (pick < 95) op = OP_REMOVE;
        else op = OP_RESERVED;
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
        else k = $urandom;
        send_item(op, k, $urandom);
    endtask

    task automatic test_directed();
        send_item(OP_LOOKUP, 32'h0, 32'h0);
        send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_INSERT, 32'h0, 32'h0);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_item(OP_INSERT, 32'h0, 32'hA5A5_5A5A);
        send_item(OP_RESERVED, 32'h0, 32'hFFFF_FFFF);
        // same first slot: forces kicks into the second table
        send_item(OP_INSERT, 32'd16, 32'd1);
        send_item(OP_INSERT, 32'd32, 32'd2);
        send_item(OP_INSERT, 32'd48, 32'd3);
        send_item(OP_LOOKUP, 32'd16, 32'd0);
        send_item(OP_INSERT, 32'd32, 32'd22);
        send_item(OP_REMOVE, 32'd0, 32'd0);
        send_item(OP_REMOVE, 32'd0, 32'd0);
        write_kick_limit(8'd0);
        send_item(OP_INSERT, 32'h1234_5678, 32'h8765_4321);
        send_item(OP_INSERT, 32'd16, 32'd9);
        write_kick_limit(8'd1);
        send_item(OP_INSERT, 32'd64, 32'd4);
        send_item(OP_INSERT, 32'd80, 32'd5);
        send_item(OP_LOOKUP, 32'd80, 32'd0);
        send_item(OP_REMOVE, 32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic test_random(int n, int idle, int stall_pct, logic [7:0] kicks);
        write_kick_limit(kicks);
        send_idle_pct = idle;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_item();
    endtask

    task automatic test_holdoff();
        write_kick_limit(8'd100);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        repeat (60) send_random_item();
    endtask

    task automatic test_pause();
        send_idle_pct = 20;
        recv_stall_pct = 20;
        repeat (100) send_random_item();
        wait_drained();
        repeat (100) send_random_item();
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        occupancy = '0;
        kick_limit = KICK_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            tab_a_vld[i] = 1'b0;
            tab_b_vld[i] = 1'b0;
            tab_a_key[i] = '0;
            tab_b_key[i] = '0;
            tab_a_val[i] = '0;
            tab_b_val[i] = '0;
        end
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(250, 0, 0, 8'd255);
        test_random(250, 85, 0, 8'd7);
        test_random(250, 0, 85, 8'd100);
        test_random(250, 29, 29, 8'd1);
        test_holdoff();
        test_pause();

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
